[rtl/lldc_pkg.sv]
// ----------------------------------------------------------------------------
// lldc_pkg
// Shared types and constants for the light level daylight classifier.
// ----------------------------------------------------------------------------
package lldc_pkg;

  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned LEVEL_W   = 7;
  localparam int unsigned MARGIN_W  = 5;
  localparam int unsigned RAW_W     = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // Operation codes.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WAKE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Daylight classes.
  localparam logic [1:0] CLS_UNKNOWN = 2'd0;
  localparam logic [1:0] CLS_NIGHT   = 2'd1;
  localparam logic [1:0] CLS_DUSK    = 2'd2;
  localparam logic [1:0] CLS_DAY     = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAY_THRESH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN        = 2'd3;

  // Reset values.
  localparam logic [PERIOD_W-1:0] RST_SAMPLE_PERIOD = 16'd10000;
  localparam logic [LEVEL_W-1:0]  RST_DAY_THRESH    = 7'd50;
  localparam logic [LEVEL_W-1:0]  RST_DARK_THRESH   = 7'd20;
  localparam logic [MARGIN_W-1:0] RST_MARGIN        = 5'd5;
  localparam logic [PERIOD_W-1:0] COUNTDOWN_WAKE    = 16'd1;

  // Inverted reading spans 1..1024; x*205 >> 11 equals x/10 over that span.
  localparam logic [10:0] FULL_SCALE  = 11'd1024;
  localparam logic [7:0]  DIV10_MUL   = 8'd205;
  localparam int unsigned DIV10_SHIFT = 11;

  typedef struct packed {
    logic               sample_taken;
    logic [LEVEL_W-1:0] light_percent;
    logic               class_changed;
    logic [1:0]         daylight_class;
    logic               sleep_allowed;
  } result_t;

endpackage

[rtl/light_level_daylight_classifier_unit.sv]
// ----------------------------------------------------------------------------
// light_level_daylight_classifier_unit
// Schedules light samples and classifies the level as night, dusk or day.
// ----------------------------------------------------------------------------
// Each result is registered into the result buffer on its input transfer.
// Throughput: one item per cycle while the output takes results; a two-entry
//   result buffer holds results during an output stall, and once it is full
//   the input waits until the cycle after the next result transfer.
// Reset (rst_n, synchronous): all registers but the result slots reset, the
//   countdown is 1 so a tick with elapsed_ms >= 1 samples; the buffer empties.
module light_level_daylight_classifier_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lldc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lldc_pkg::CFG_DAT_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_operation,
  input  logic [lldc_pkg::PERIOD_W-1:0]       in_elapsed_ms,
  input  logic [lldc_pkg::RAW_W-1:0]          in_raw_light,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_sample_taken,
  output logic [lldc_pkg::LEVEL_W-1:0]        out_light_percent,
  output logic                                out_class_changed,
  output logic [1:0]                          out_daylight_class,
  output logic                                out_sleep_allowed
);
  import lldc_pkg::*;

  // Configuration registers.
  logic [PERIOD_W-1:0] period_r;
  logic [LEVEL_W-1:0]  day_r;
  logic [LEVEL_W-1:0]  dark_r;
  logic [MARGIN_W-1:0] margin_r;

  // Block state.
  logic [PERIOD_W-1:0] countdown_r, countdown_nxt;
  logic [LEVEL_W-1:0]  level_r, level_nxt;
  logic                level_known_r, level_known_nxt;
  logic [1:0]          class_r, class_nxt;

  // Result buffer.
  result_t   slot0_r, slot1_r;
  logic [1:0] count_r;
  result_t   res;

  logic push, pop;
  logic [10:0] inv_raw;
  logic [18:0] scaled;
  logic [LEVEL_W-1:0] new_level;
  logic [LEVEL_W:0] day_m, dark_m, lvl_x, day_x, dark_x;
  logic issue;
  logic [1:0] issued_class;
  logic sample_due;

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid & in_ready;
  assign out_valid = (count_r != 2'd0);
  assign pop      = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= RST_SAMPLE_PERIOD;
      day_r    <= RST_DAY_THRESH;
      dark_r   <= RST_DARK_THRESH;
      margin_r <= RST_MARGIN;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_PERIOD: period_r <= cfg_wdata[PERIOD_W-1:0];
        REG_DAY_THRESH:    day_r    <= cfg_wdata[LEVEL_W-1:0];
        REG_DARK_THRESH:   dark_r   <= cfg_wdata[LEVEL_W-1:0];
        REG_MARGIN:        margin_r <= cfg_wdata[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Level from the raw reading: (1024 - raw) / 10 by reciprocal multiply.
  assign inv_raw   = FULL_SCALE - {1'b0, in_raw_light};
  assign scaled    = {8'd0, inv_raw} * {11'd0, DIV10_MUL};
  assign new_level = scaled[DIV10_SHIFT +: LEVEL_W];

  assign lvl_x  = {1'b0, new_level};
  assign day_x  = {1'b0, day_r};
  assign dark_x = {1'b0, dark_r};
  assign day_m  = day_x + {3'd0, margin_r};
  assign dark_m = dark_x + {3'd0, margin_r};

  always_comb begin
    issue        = 1'b0;
    issued_class = class_r;
    case (class_r)
      CLS_NIGHT: begin
        if (lvl_x > day_m) begin
          issue = 1'b1; issued_class = CLS_DAY;
        end else if (lvl_x > dark_m) begin
          issue = 1'b1; issued_class = CLS_DUSK;
        end
      end
      CLS_DUSK: begin
        if (lvl_x < dark_x) begin
          issue = 1'b1; issued_class = CLS_NIGHT;
        end else if (lvl_x > day_m) begin
          issue = 1'b1; issued_class = CLS_DAY;
        end
      end
      CLS_DAY: begin
        if (lvl_x < dark_x) begin
          issue = 1'b1; issued_class = CLS_NIGHT;
        end else if (lvl_x < day_x) begin
          issue = 1'b1; issued_class = CLS_DUSK;
        end
      end
      default: begin
        issue = 1'b1;
        if (lvl_x < dark_x)     issued_class = CLS_NIGHT;
        else if (lvl_x > day_x) issued_class = CLS_DAY;
        else                    issued_class = CLS_DUSK;
      end
    endcase
  end

  // A zero countdown means sampling is stopped until the next wake.
  assign sample_due = (in_operation == OP_TICK) && (countdown_r != '0) &&
                      (countdown_r <= in_elapsed_ms);

  always_comb begin
    countdown_nxt   = countdown_r;
    level_nxt       = level_r;
    level_known_nxt = level_known_r;
    class_nxt       = class_r;
    case (in_operation)
      OP_TICK: begin
        if (sample_due) begin
          countdown_nxt   = period_r;
          level_nxt       = new_level;
          level_known_nxt = 1'b1;
          class_nxt       = issued_class;
        end else if (countdown_r != '0) begin
          countdown_nxt = countdown_r - in_elapsed_ms;
        end
      end
      OP_WAKE: countdown_nxt = COUNTDOWN_WAKE;
      default: ;
    endcase
    res.sample_taken   = sample_due;
    res.light_percent  = level_nxt;
    res.class_changed  = sample_due & issue;
    res.daylight_class = class_nxt;
    res.sleep_allowed  = level_known_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      countdown_r   <= COUNTDOWN_WAKE;
      level_r       <= '0;
      level_known_r <= 1'b0;
      class_r       <= CLS_UNKNOWN;
    end else if (push) begin
      countdown_r   <= countdown_nxt;
      level_r       <= level_nxt;
      level_known_r <= level_known_nxt;
      class_r       <= class_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Slot 0 is the head; slot 1 holds a second result while the output stalls.
  always_ff @(posedge clk) begin
    if (pop) begin
      slot0_r <= (push && count_r == 2'd1) ? res : slot1_r;
      if (push && count_r == 2'd2) slot1_r <= res;
    end else if (push) begin
      if (count_r == 2'd0) slot0_r <= res;
      else                 slot1_r <= res;
    end
  end

  assign out_sample_taken   = slot0_r.sample_taken;
  assign out_light_percent  = slot0_r.light_percent;
  assign out_class_changed  = slot0_r.class_changed;
  assign out_daylight_class = slot0_r.daylight_class;
  assign out_sleep_allowed  = slot0_r.sleep_allowed;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result buffer count out of range");

  a_wake_reload: assert property (@(posedge clk) disable iff (!rst_n)
    push && in_operation == OP_WAKE |=> countdown_r == COUNTDOWN_WAKE)
    else $error("wake did not reschedule a sample");

  a_known_has_class: assert property (@(posedge clk) disable iff (!rst_n)
    level_known_r |-> class_r != CLS_UNKNOWN)
    else $error("class unknown after a sample was taken");

  a_change_needs_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_class_changed |-> out_sample_taken && out_sleep_allowed)
    else $error("class issued without a sample");

  a_sample_sets_known: assert property (@(posedge clk) disable iff (!rst_n)
    push && sample_due |=> level_known_r)
    else $error("sample did not mark the level known");

endmodule
